[rtl/domain_suffix_blocklist_match_assert.svh]
// Assertion macros for the domain suffix blocklist matcher.
// DSBM_ASSERT_IMP checks that a condition implies another in the same cycle.
// DSBM_ASSERT_NXT checks that a condition implies another in the next cycle.
`ifndef DOMAIN_SUFFIX_BLOCKLIST_MATCH_ASSERT_SVH
`define DOMAIN_SUFFIX_BLOCKLIST_MATCH_ASSERT_SVH
`ifndef SYNTHESIS
`define DSBM_ASSERT_IMP(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);
`define DSBM_ASSERT_NXT(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSBM_ASSERT_IMP(name, clock, resetn, ante, cons, msg)
`define DSBM_ASSERT_NXT(name, clock, resetn, ante, cons, msg)
`endif
`endif

[rtl/dsbm_pkg.sv]
// ---------------------------------------------------------------------------
// dsbm_pkg
// Types and constants shared by the domain suffix blocklist matcher.
// ---------------------------------------------------------------------------
package dsbm_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_INVAL = 2'd2;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] rule_slot;
        logic [7:0] byte_value;
        logic       is_wildcard;
        logic       last;
    } dsbm_in_t;

    typedef struct packed {
        logic blocked;
        logic status;
    } dsbm_out_t;

    typedef struct packed {
        logic       valid;
        logic       wild;
        logic [7:0] len;
    } dsbm_meta_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_INIT,
        ST_META_RD,
        ST_META_CHK,
        ST_CHAR_RD,
        ST_CHAR_CMP,
        ST_DOT_RD,
        ST_DOT_CMP,
        ST_NEXT,
        ST_REPORT
    } dsbm_state_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic scan_start;
        logic meta_read;
        logic char_read;
        logic char_next;
        logic dot_read;
        logic slot_next;
        logic set_hit;
        logic report;
    } dsbm_cmd_t;

    typedef struct packed {
        logic query_end;
        logic overlong;
        logic last_slot;
        logic meta_skip;
        logic rlen_zero;
        logic chars_last;
        logic need_dot;
        logic char_eq;
        logic dot_eq;
    } dsbm_stat_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

[rtl/dsbm_ctrl.sv]
// ---------------------------------------------------------------------------
// dsbm_ctrl
// Sequencer: reset clearing pass, word intake and the rule scan at name end.
// ---------------------------------------------------------------------------
module dsbm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dsbm_pkg::dsbm_stat_t stat,
    output dsbm_pkg::dsbm_cmd_t  cmd,
    output logic                 busy
);
    import dsbm_pkg::*;

    dsbm_state_t state_reg;
    dsbm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.last_slot)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (stat.query_end)
                    begin
                        state_next = ST_SCAN_INIT;
                    end
                end
            end
            ST_SCAN_INIT:
            begin
                if (stat.overlong)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_META_RD;
                end
            end
            ST_META_RD:
            begin
                cmd.meta_read = 1'b1;
                state_next    = ST_META_CHK;
            end
            ST_META_CHK:
            begin
                if (stat.meta_skip)
                begin
                    state_next = ST_NEXT;
                end
                else if (!stat.rlen_zero)
                begin
                    state_next = ST_CHAR_RD;
                end
                else if (stat.need_dot)
                begin
                    state_next = ST_DOT_RD;
                end
                else
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_REPORT;
                end
            end
            ST_CHAR_RD:
            begin
                cmd.char_read = 1'b1;
                state_next    = ST_CHAR_CMP;
            end
            ST_CHAR_CMP:
            begin
                if (!stat.char_eq)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    cmd.char_next = 1'b1;
                    if (!stat.chars_last)
                    begin
                        state_next = ST_CHAR_RD;
                    end
                    else if (stat.need_dot)
                    begin
                        state_next = ST_DOT_RD;
                    end
                    else
                    begin
                        cmd.set_hit = 1'b1;
                        state_next  = ST_REPORT;
                    end
                end
            end
            ST_DOT_RD:
            begin
                cmd.dot_read = 1'b1;
                state_next   = ST_DOT_CMP;
            end
            ST_DOT_CMP:
            begin
                if (stat.dot_eq)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_REPORT;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (stat.last_slot)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                    state_next    = ST_META_RD;
                end
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/dsbm_dp.sv]
// ---------------------------------------------------------------------------
// dsbm_dp
// Rule and query stores, counters and the byte comparator.
// ---------------------------------------------------------------------------
module dsbm_dp #(
    parameter int NUM_RULES    = 64,
    parameter int MAX_NAME_LEN = 253
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsbm_pkg::dsbm_in_t   item,
    input  dsbm_pkg::dsbm_cmd_t  cmd,
    output dsbm_pkg::dsbm_stat_t stat,
    output dsbm_pkg::dsbm_out_t  result
);
    import dsbm_pkg::*;

    localparam int SLOT_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int RADDR_W = SLOT_W + 8;

    dsbm_meta_t meta_mem [NUM_RULES];
    logic [7:0] rmem [NUM_RULES * 256];
    logic [7:0] qmem [256];

    dsbm_meta_t  meta_reg;
    logic [7:0]  qrd_reg;
    logic [7:0]  rrd_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [7:0]  idx_reg;
    logic [7:0]  load_pos_reg;
    logic [8:0]  qlen_reg;
    logic [8:0]  scan_len_reg;
    logic        hit_reg;

    logic [7:0]  ch;
    logic [SLOT_W-1:0] islot;
    logic        slot_ok;
    logic        rule_store;
    logic [7:0]  load_pos_next;
    logic        q_store;
    logic [8:0]  qlen_inc;
    dsbm_meta_t  meta_wr;
    logic [8:0]  off;
    logic [7:0]  q_addr;

    assign ch      = fold_case(item.byte_value);
    assign islot   = SLOT_W'(item.rule_slot);
    assign slot_ok = (32'(item.rule_slot) < NUM_RULES);

    assign rule_store    = (load_pos_reg < 8'(MAX_NAME_LEN));
    assign load_pos_next = rule_store ? (load_pos_reg + 8'd1) : load_pos_reg;
    assign q_store       = (qlen_reg < 9'(MAX_NAME_LEN));
    assign qlen_inc      = (qlen_reg <= 9'(MAX_NAME_LEN)) ? (qlen_reg + 9'd1) : qlen_reg;

    always_comb
    begin
        meta_wr = '0;
        if (item.mode == MODE_LOAD && item.last)
        begin
            meta_wr.valid = 1'b1;
            meta_wr.wild  = item.is_wildcard;
            meta_wr.len   = load_pos_next;
        end
    end

    // Offset of the rule's suffix within the query.
    assign off    = scan_len_reg - {1'b0, meta_reg.len};
    assign q_addr = cmd.dot_read ? (off[7:0] - 8'd1) : (off[7:0] + idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            meta_mem[slot_reg] <= '0;
        end
        else if (cmd.accept && slot_ok &&
                 (item.mode == MODE_LOAD || item.mode == MODE_INVAL))
        begin
            meta_mem[islot] <= meta_wr;
        end
        if (cmd.meta_read)
        begin
            meta_reg <= meta_mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && slot_ok && item.mode == MODE_LOAD && rule_store)
        begin
            rmem[RADDR_W'({islot, load_pos_reg})] <= ch;
        end
        if (cmd.char_read)
        begin
            rrd_reg <= rmem[RADDR_W'({slot_reg, idx_reg})];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && item.mode == MODE_QUERY && q_store)
        begin
            qmem[qlen_reg[7:0]] <= ch;
        end
        if (cmd.char_read || cmd.dot_read)
        begin
            qrd_reg <= qmem[q_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            idx_reg      <= '0;
            load_pos_reg <= '0;
            qlen_reg     <= '0;
            scan_len_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step || cmd.slot_next)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
            else if (cmd.scan_start)
            begin
                slot_reg <= '0;
            end
            if (cmd.meta_read)
            begin
                idx_reg <= '0;
            end
            else if (cmd.char_next)
            begin
                idx_reg <= idx_reg + 8'd1;
            end
            if (cmd.scan_start)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.set_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.accept && slot_ok && item.mode == MODE_LOAD)
            begin
                load_pos_reg <= item.last ? 8'd0 : load_pos_next;
            end
            if (cmd.accept && item.mode == MODE_QUERY)
            begin
                if (item.last)
                begin
                    scan_len_reg <= qlen_inc;
                    qlen_reg     <= '0;
                    hit_reg      <= 1'b0;
                end
                else
                begin
                    qlen_reg <= qlen_inc;
                end
            end
        end
    end

    always_comb
    begin
        stat.query_end  = (item.mode == MODE_QUERY) && item.last;
        stat.overlong   = (scan_len_reg > 9'(MAX_NAME_LEN));
        stat.last_slot  = (32'(slot_reg) == NUM_RULES - 1);
        stat.meta_skip  = !meta_reg.valid || ({1'b0, meta_reg.len} > scan_len_reg);
        stat.rlen_zero  = (meta_reg.len == 8'd0);
        stat.chars_last = (idx_reg == (meta_reg.len - 8'd1));
        stat.need_dot   = (off != 9'd0) && !meta_reg.wild;
        stat.char_eq    = (qrd_reg == rrd_reg);
        stat.dot_eq     = (qrd_reg == DOT_CHAR);
    end

    assign result.blocked = hit_reg;
    assign result.status  = stat.overlong;

endmodule

[rtl/domain_suffix_blocklist_match.sv]
// ---------------------------------------------------------------------------
// domain_suffix_blocklist_match
// Matches streamed query names against a table of domain suffix rules.
// ---------------------------------------------------------------------------
// Channel   Handshake            Payload
// item      start / busy         mode, rule_slot, byte_value, is_wildcard, last
// result    done (one cycle)     blocked, status
//
// Rule bytes, invalidations and query bytes that do not end a name are taken
// without leaving idle, so busy stays low. A query word with last set starts
// a scan of the rule table: for each slot the descriptor is read and checked,
// the rule bytes are compared one by one with the end of the query and the
// dot before that suffix is checked where needed; a miss steps to the next slot.
// The scan stops at the first hit. An overlong name reports with no rule scan.
// After reset a clearing pass over every rule slot holds busy high.
// The receiver cannot stall: the result is shown for one cycle with done.
// ---------------------------------------------------------------------------
`include "domain_suffix_blocklist_match_assert.svh"

module domain_suffix_blocklist_match #(
    parameter int NUM_RULES    = 64,
    parameter int MAX_NAME_LEN = 253
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dsbm_pkg::dsbm_in_t  item,
    output logic                done,
    output dsbm_pkg::dsbm_out_t result
);
    import dsbm_pkg::*;

    dsbm_cmd_t  cmd;
    dsbm_stat_t stat;
    logic       name_end;

    dsbm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dsbm_dp #(
        .NUM_RULES    (NUM_RULES),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    assign done     = cmd.report;
    assign name_end = start && !busy && item.mode == MODE_QUERY && item.last;

    `DSBM_ASSERT_NXT(a_end_busy, clk, rst_n, name_end, busy, "name end started no scan")
    `DSBM_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done && !busy, "strobe too long")
    `DSBM_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy, "result strobe while idle")
    `DSBM_ASSERT_IMP(a_status_excl, clk, rst_n, done, !(result.blocked && result.status), "overlong blocked")

endmodule
